/* rtl/core/tss_pkg.sv */
// ----------------------------------------------------------------------------
// tss_pkg
// shared types and constants of the triangle scanline span block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tss_pkg;

  // width of the span index field
  localparam int IDX_W = 13;

  // per-item control flags that ride along the divider stages
  typedef struct packed {
    logic flat;
    logic in_range;
    logic last;
    logic use_end;
  } tss_ctl_t;

endpackage
`default_nettype wire

/* rtl/core/tss_if.sv */
// ----------------------------------------------------------------------------
// tss_if
// valid/ready channels for triangle queries and span results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface tss_in_if #(parameter int CB = 12);
  logic                        valid;
  logic                        ready;
  logic signed [CB-1:0]        ax;
  logic signed [CB-1:0]        ay;
  logic signed [CB-1:0]        bx;
  logic signed [CB-1:0]        by_coord;
  logic signed [CB-1:0]        cx;
  logic signed [CB-1:0]        cy;
  logic [tss_pkg::IDX_W-1:0]   span_index;
  modport source(output valid, ax, ay, bx, by_coord, cx, cy, span_index, input ready);
  modport sink(input valid, ax, ay, bx, by_coord, cx, cy, span_index, output ready);
endinterface

interface tss_out_if #(parameter int CB = 12);
  logic                 valid;
  logic                 ready;
  logic signed [CB-1:0] row_y;
  logic signed [CB-1:0] left_x;
  logic signed [CB-1:0] right_x;
  logic                 span_valid;
  logic                 last_span;
  modport source(output valid, row_y, left_x, right_x, span_valid, last_span, input ready);
  modport sink(input valid, row_y, left_x, right_x, span_valid, last_span, output ready);
endinterface
`default_nettype wire

/* rtl/core/tss_setup.sv */
// ----------------------------------------------------------------------------
// tss_setup
// vertex sort, span decode and edge numerator product, three register stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tss_setup #(
  parameter int CB = 12
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic signed [CB-1:0]       ax,
  input  wire logic signed [CB-1:0]       ay,
  input  wire logic signed [CB-1:0]       bx,
  input  wire logic signed [CB-1:0]       by_coord,
  input  wire logic signed [CB-1:0]       cx,
  input  wire logic signed [CB-1:0]       cy,
  input  wire logic [tss_pkg::IDX_W-1:0]  span_index,
  output logic                            out_valid,
  output tss_pkg::tss_ctl_t               ctl,
  output logic signed [CB-1:0]            row,
  output logic signed [CB-1:0]            flat_l,
  output logic signed [CB-1:0]            flat_r,
  output logic signed [CB-1:0]            end_x,
  output logic signed [CB-1:0]            xs_l,
  output logic signed [CB-1:0]            xs_s,
  output logic                            neg_l,
  output logic                            neg_s,
  output logic [2*CB:0]                   mag_l,
  output logic [2*CB:0]                   mag_s,
  output logic [CB:0]                     den_l,
  output logic [CB:0]                     den_s
);
  import tss_pkg::*;

  localparam int CW = (CB + 2 > IDX_W) ? CB + 2 : IDX_W;
  localparam int PW = 2 * CB + 2;

  // stage 1: sorted vertices
  logic                 v1_r;
  logic signed [CB-1:0] x0_r, x1_r, x2_r, y0_r, y1_r, y2_r;
  logic [IDX_W-1:0]     idx1_r;

  logic signed [CB-1:0] sx0, sx1, sx2, sy0, sy1, sy2, tx, ty;

  always_comb begin
    sx0 = ax; sy0 = ay; sx1 = bx; sy1 = by_coord; sx2 = cx; sy2 = cy;
    if (sy0 > sy1) begin
      tx = sx0; ty = sy0; sx0 = sx1; sy0 = sy1; sx1 = tx; sy1 = ty;
    end
    if (sy1 > sy2) begin
      tx = sx1; ty = sy1; sx1 = sx2; sy1 = sy2; sx2 = tx; sy2 = ty;
    end
    if (sy0 > sy1) begin
      tx = sx0; ty = sy0; sx0 = sx1; sy0 = sy1; sx1 = tx; sy1 = ty;
    end
    tx = sx0;
    ty = sy0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= sx0; x1_r <= sx1; x2_r <= sx2;
      y0_r <= sy0; y1_r <= sy1; y2_r <= sy2;
      idx1_r <= span_index;
    end
  end

  // stage 2: span decode
  logic                 v2_r;
  tss_ctl_t             ctl2_r;
  logic signed [CB-1:0] row2_r, fl2_r, fr2_r, endx2_r, x0_2_r, xs2_r;
  logic signed [CB:0]   dl2_r, ds2_r;
  logic [CB-1:0]        kl2_r, ks2_r, hl2_r, hs2_r;

  logic [CB:0]          t01, t12, t02;
  logic [CB-1:0]        dy01, dy12, dy02;
  logic [CW-1:0]        idx_w, n_upper, n_total, k_long_w, k_short_w;
  logic                 upper;
  logic [CB-1:0]        hs;
  logic signed [CB-1:0] mn, mx;
  tss_ctl_t             ctl_nxt;

  always_comb begin
    t01  = {y1_r[CB-1], y1_r} - {y0_r[CB-1], y0_r};
    t12  = {y2_r[CB-1], y2_r} - {y1_r[CB-1], y1_r};
    t02  = {y2_r[CB-1], y2_r} - {y0_r[CB-1], y0_r};
    dy01 = t01[CB-1:0];
    dy12 = t12[CB-1:0];
    dy02 = t02[CB-1:0];
    idx_w   = {{(CW-IDX_W){1'b0}}, idx1_r};
    n_upper = {{(CW-CB){1'b0}}, dy01} + CW'(1);
    n_total = {{(CW-CB){1'b0}}, dy02} + CW'(2);
    upper   = idx_w < n_upper;
    k_long_w  = upper ? idx_w : idx_w - CW'(1);
    k_short_w = upper ? idx_w : idx_w - n_upper;
    hs      = upper ? dy01 : dy12;
    ctl_nxt.flat     = (dy02 == '0);
    ctl_nxt.in_range = ctl_nxt.flat ? (idx_w == '0) : (idx_w < n_total);
    ctl_nxt.last     = ctl_nxt.flat ? 1'b1 : (idx_w == n_total - CW'(1));
    ctl_nxt.use_end  = (hs == '0);
    mn = (x0_r < x1_r) ? x0_r : x1_r;
    mn = (mn < x2_r) ? mn : x2_r;
    mx = (x0_r > x1_r) ? x0_r : x1_r;
    mx = (mx > x2_r) ? mx : x2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl2_r  <= ctl_nxt;
      row2_r  <= y0_r + $signed(k_long_w[CB-1:0]);
      fl2_r   <= mn;
      fr2_r   <= mx;
      endx2_r <= upper ? x1_r : x2_r;
      x0_2_r  <= x0_r;
      xs2_r   <= upper ? x0_r : x1_r;
      dl2_r   <= {x2_r[CB-1], x2_r} - {x0_r[CB-1], x0_r};
      ds2_r   <= upper ? ({x1_r[CB-1], x1_r} - {x0_r[CB-1], x0_r})
                       : ({x2_r[CB-1], x2_r} - {x1_r[CB-1], x1_r});
      kl2_r   <= k_long_w[CB-1:0];
      ks2_r   <= k_short_w[CB-1:0];
      hl2_r   <= dy02;
      hs2_r   <= hs;
    end
  end

  // stage 3: numerator 2*d*k + h, split into sign and magnitude
  logic signed [PW-1:0] pl, ps, nl, ns, abs_l, abs_s;

  always_comb begin
    pl = PW'(dl2_r * $signed({1'b0, kl2_r}));
    ps = PW'(ds2_r * $signed({1'b0, ks2_r}));
    nl = (pl <<< 1) + $signed({{(PW-CB){1'b0}}, hl2_r});
    ns = (ps <<< 1) + $signed({{(PW-CB){1'b0}}, hs2_r});
    abs_l = nl[PW-1] ? -nl : nl;
    abs_s = ns[PW-1] ? -ns : ns;
  end

  logic v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl    <= ctl2_r;
      row    <= row2_r;
      flat_l <= fl2_r;
      flat_r <= fr2_r;
      end_x  <= endx2_r;
      xs_l   <= x0_2_r;
      xs_s   <= xs2_r;
      neg_l  <= nl[PW-1];
      neg_s  <= ns[PW-1];
      // magnitude never exceeds 2*CB+1 bits
      mag_l  <= abs_l[2*CB:0];
      mag_s  <= abs_s[2*CB:0];
      den_l  <= {hl2_r, 1'b0};
      den_s  <= {hs2_r, 1'b0};
    end
  end

  assign out_valid = v3_r;

endmodule
`default_nettype wire

/* rtl/core/tss_div.sv */
// ----------------------------------------------------------------------------
// tss_div
// two-lane restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tss_div #(
  parameter int NW = 25,
  parameter int DW = 13,
  parameter int QW = 12,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] num_a,
  input  wire logic [DW-1:0] den_a,
  input  wire logic [NW-1:0] num_b,
  input  wire logic [DW-1:0] den_b,
  input  wire logic [SW-1:0] side_in,
  output logic               out_valid,
  output logic [QW-1:0]      quo_a,
  output logic [QW-1:0]      quo_b,
  output logic [SW-1:0]      side_out
);

  logic          v_r    [QW];
  logic [NW-1:0] rema_r [QW];
  logic [NW-1:0] remb_r [QW];
  logic [DW-1:0] dena_r [QW];
  logic [DW-1:0] denb_r [QW];
  logic [QW-1:0] qa_r   [QW];
  logic [QW-1:0] qb_r   [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_st
    localparam int B = QW - 1 - s;
    logic          v_in;
    logic [NW-1:0] ra_in, rb_in;
    logic [DW-1:0] da_in, db_in;
    logic [QW-1:0] qa_in, qb_in;
    logic [SW-1:0] sd_in;
    logic [NW:0]   tra, trb;

    if (s == 0) begin : g_first
      assign v_in  = in_valid;
      assign ra_in = num_a;
      assign rb_in = num_b;
      assign da_in = den_a;
      assign db_in = den_b;
      assign qa_in = '0;
      assign qb_in = '0;
      assign sd_in = side_in;
    end else begin : g_next
      assign v_in  = v_r[s-1];
      assign ra_in = rema_r[s-1];
      assign rb_in = remb_r[s-1];
      assign da_in = dena_r[s-1];
      assign db_in = denb_r[s-1];
      assign qa_in = qa_r[s-1];
      assign qb_in = qb_r[s-1];
      assign sd_in = side_r[s-1];
    end

    // trial subtract of the shifted divisor, borrow means the bit is zero
    assign tra = {1'b0, ra_in} - ({{(NW+1-DW){1'b0}}, da_in} << B);
    assign trb = {1'b0, rb_in} - ({{(NW+1-DW){1'b0}}, db_in} << B);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rema_r[s] <= tra[NW] ? ra_in : tra[NW-1:0];
        remb_r[s] <= trb[NW] ? rb_in : trb[NW-1:0];
        dena_r[s] <= da_in;
        denb_r[s] <= db_in;
        qa_r[s]   <= {qa_in[QW-2:0], ~tra[NW]};
        qb_r[s]   <= {qb_in[QW-2:0], ~trb[NW]};
        side_r[s] <= sd_in;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign quo_a     = qa_r[QW-1];
  assign quo_b     = qb_r[QW-1];
  assign side_out  = side_r[QW-1];

endmodule
`default_nettype wire

/* rtl/core/tss_fin.sv */
// ----------------------------------------------------------------------------
// tss_fin
// edge x assembly, span ordering and the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tss_fin #(
  parameter int CB = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire tss_pkg::tss_ctl_t    ctl,
  input  wire logic signed [CB-1:0] row,
  input  wire logic signed [CB-1:0] flat_l,
  input  wire logic signed [CB-1:0] flat_r,
  input  wire logic signed [CB-1:0] end_x,
  input  wire logic signed [CB-1:0] xs_l,
  input  wire logic signed [CB-1:0] xs_s,
  input  wire logic                 neg_l,
  input  wire logic                 neg_s,
  input  wire logic [CB-1:0]        quo_l,
  input  wire logic [CB-1:0]        quo_s,
  output logic                      en,
  tss_out_if.source                 out_ch
);
  import tss_pkg::*;

  logic                 valid_r;
  logic signed [CB-1:0] row_r, lx_r, rx_r;
  logic                 sv_r, last_r;

  logic signed [CB:0]   ql, qs, sa, sb;
  logic signed [CB-1:0] xa, xb, lx_nxt, rx_nxt, row_nxt;

  always_comb begin
    ql = neg_l ? -$signed({1'b0, quo_l}) : $signed({1'b0, quo_l});
    qs = neg_s ? -$signed({1'b0, quo_s}) : $signed({1'b0, quo_s});
    sa = $signed({xs_l[CB-1], xs_l}) + ql;
    sb = $signed({xs_s[CB-1], xs_s}) + qs;
    xa = sa[CB-1:0];
    xb = ctl.use_end ? end_x : sb[CB-1:0];
    if (!ctl.in_range) begin
      lx_nxt = '0; rx_nxt = '0; row_nxt = '0;
    end else if (ctl.flat) begin
      lx_nxt = flat_l; rx_nxt = flat_r; row_nxt = row;
    end else begin
      lx_nxt  = (xa > xb) ? xb : xa;
      rx_nxt  = (xa > xb) ? xa : xb;
      row_nxt = row;
    end
  end

  assign en = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_r  <= row_nxt;
      lx_r   <= lx_nxt;
      rx_r   <= rx_nxt;
      sv_r   <= ctl.in_range;
      last_r <= ctl.in_range && ctl.last;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.row_y      = row_r;
  assign out_ch.left_x     = lx_r;
  assign out_ch.right_x    = rx_r;
  assign out_ch.span_valid = sv_r;
  assign out_ch.last_span  = last_r;

endmodule
`default_nettype wire

/* rtl/core/triangle_scanline_span_top.sv */
// ----------------------------------------------------------------------------
// triangle_scanline_span_top
// returns one span of a scanline triangle fill per query
// ----------------------------------------------------------------------------
// channel   dir  contents
// in_ch     in   three vertices (x, y) and the span index
// out_ch    out  row, left and right x, span valid, last span
//
// one query per cycle while the output is not stalled; stages: sort, decode,
// multiply, one stage per quotient bit in the edge divider, output register
// all stages advance together while the output register is empty or taken
// a stall freezes every stage, in_ch.ready is high while out_ch is empty or taken
// synchronous reset clears the stage valid bits only
`timescale 1ns / 1ps
`default_nettype none
module triangle_scanline_span_top #(
  parameter int COORD_BITS = 12
) (
  input wire logic  clk,
  input wire logic  rst_n,
  tss_in_if.sink    in_ch,
  tss_out_if.source out_ch
);
  import tss_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int NW = 2 * CB + 1;
  localparam int DW = CB + 1;
  localparam int CT = $bits(tss_ctl_t);
  localparam int SW = CT + 2 + 6 * CB;

  logic                 en;
  logic                 v3;
  tss_ctl_t             ctl3, ctl_d;
  logic signed [CB-1:0] row3, fl3, fr3, ex3, xl3, xs3;
  logic signed [CB-1:0] row_d, fl_d, fr_d, ex_d, xl_d, xs_d;
  logic                 ngl3, ngs3, ngl_d, ngs_d;
  logic [NW-1:0]        mag_l, mag_s;
  logic [DW-1:0]        den_l, den_s;
  logic                 v_d;
  logic [CB-1:0]        q_l, q_s;
  logic [SW-1:0]        side_in, side_out;

  assign in_ch.ready = en;

  tss_setup #(.CB(CB)) u_setup (
    .clk, .rst_n, .en,
    .in_valid(in_ch.valid),
    .ax(in_ch.ax), .ay(in_ch.ay), .bx(in_ch.bx), .by_coord(in_ch.by_coord),
    .cx(in_ch.cx), .cy(in_ch.cy), .span_index(in_ch.span_index),
    .out_valid(v3), .ctl(ctl3), .row(row3), .flat_l(fl3), .flat_r(fr3),
    .end_x(ex3), .xs_l(xl3), .xs_s(xs3), .neg_l(ngl3), .neg_s(ngs3),
    .mag_l, .mag_s, .den_l, .den_s
  );

  assign side_in = {ctl3, ngl3, ngs3, row3, fl3, fr3, ex3, xl3, xs3};

  tss_div #(.NW(NW), .DW(DW), .QW(CB), .SW(SW)) u_div (
    .clk, .rst_n, .en,
    .in_valid(v3),
    .num_a(mag_l), .den_a(den_l), .num_b(mag_s), .den_b(den_s),
    .side_in,
    .out_valid(v_d), .quo_a(q_l), .quo_b(q_s), .side_out
  );

  assign {ctl_d, ngl_d, ngs_d, row_d, fl_d, fr_d, ex_d, xl_d, xs_d} = side_out;

  tss_fin #(.CB(CB)) u_fin (
    .clk, .rst_n,
    .in_valid(v_d), .ctl(ctl_d), .row(row_d), .flat_l(fl_d), .flat_r(fr_d),
    .end_x(ex_d), .xs_l(xl_d), .xs_s(xs_d), .neg_l(ngl_d), .neg_s(ngs_d),
    .quo_l(q_l), .quo_s(q_s), .en, .out_ch
  );

  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.span_valid |-> out_ch.left_x <= out_ch.right_x)
    else $error("span left end beyond right end");

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_span |-> out_ch.span_valid)
    else $error("last span flagged on an invalid span");

  a_zero_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.span_valid |->
      out_ch.row_y == '0 && out_ch.left_x == '0 && out_ch.right_x == '0)
    else $error("invalid span carries nonzero fields");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == (!out_ch.valid || out_ch.ready))
    else $error("input ready does not track output stall");

endmodule
`default_nettype wire
